// ===== sv/vccc_pkg.sv =====
// Shared types, codes and constants of the vector console channel controller.
package vccc_pkg;

  localparam int unsigned KEY_RING_DEPTH = 64;
  localparam int unsigned RING_AW = (KEY_RING_DEPTH > 1) ? $clog2(KEY_RING_DEPTH) : 1;

  localparam logic [2:0] OP_FUNCTION   = 3'd0;
  localparam logic [2:0] OP_OUTPUT     = 3'd1;
  localparam logic [2:0] OP_READ       = 3'd2;
  localparam logic [2:0] OP_QUEUE      = 3'd3;
  localparam logic [2:0] OP_ACTIVATE   = 3'd4;
  localparam logic [2:0] OP_DISCONNECT = 3'd5;

  localparam logic [2:0] ACT_NONE    = 3'd0;
  localparam logic [2:0] ACT_SET_X   = 3'd1;
  localparam logic [2:0] ACT_SET_Y   = 3'd2;
  localparam logic [2:0] ACT_CHARS   = 3'd3;
  localparam logic [2:0] ACT_DOT     = 3'd4;
  localparam logic [2:0] ACT_READ    = 3'd5;
  localparam logic [2:0] ACT_REFRESH = 3'd6;

  localparam logic [11:0] SEL_CHAR_S_L = 12'o7000;
  localparam logic [11:0] SEL_CHAR_M_L = 12'o7001;
  localparam logic [11:0] SEL_CHAR_L_L = 12'o7002;
  localparam logic [11:0] SEL_DOT_L    = 12'o7010;
  localparam logic [11:0] SEL_DOT_R    = 12'o7110;
  localparam logic [11:0] SEL_KEYIN    = 12'o7020;
  localparam logic [11:0] SEL_CHAR_S_R = 12'o7100;
  localparam logic [11:0] SEL_CHAR_M_R = 12'o7101;
  localparam logic [11:0] SEL_CHAR_L_R = 12'o7102;

  localparam logic [5:0] TOP_Y_MIN = 6'o70;
  localparam logic [5:0] TOP_X_MIN = 6'o60;

  localparam logic CFG_LEFT_OFFSET  = 1'b0;
  localparam logic CFG_RIGHT_OFFSET = 1'b1;

  typedef struct packed {
    logic [2:0]  operation;
    logic [11:0] word;
    logic [7:0]  key_code;
  } in_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  action;
    logic [10:0] coordinate;
    logic [5:0]  char_high;
    logic [5:0]  char_low;
    logic [1:0]  font;
    logic [7:0]  read_data;
  } out_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

// ===== sv/vector_console_channel_controller.sv =====
// Top level of the vector console channel controller.
// Usage: each input word carries one channel access (function, output word,
// read, queue key, activate, disconnect) and yields exactly one result word.
// Both channels use valid/ready; the configuration port writes the left or
// right screen X offset with cfg_we_i, cfg_index_i and cfg_data_i.
// The result word is registered and valid the cycle after acceptance.
// Throughput: one word per cycle when not stalled, set by the single result
// register after the decode logic; the key ring port is read once per pop.
// While a result is held and out_ready_i is low, in_ready_o is low, so the
// pending result holds unchanged; an input word is taken in the same cycle
// that the held result is taken.
// Reset: modes, font, side, refresh flag, poll phase and ring pointers
// clear, the offsets return to 0 and 512; the key ring needs no clearing
// pass, since only written entries are ever read.
module vector_console_channel_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_index_i,
  input  logic [9:0]     cfg_data_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  vccc_pkg::in_t  in_word_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output vccc_pkg::out_t out_word_o
);

  logic [9:0]  left_off_q, right_off_q;
  logic [11:0] mode_q, mode_d;
  logic [1:0]  font_q, font_d;
  logic        right_q, right_d;
  logic [1:0]  phase_q, phase_d;
  logic        refresh_q, refresh_d;
  logic        out_valid_q;
  logic        use_ring_q, use_ring_d;
  vccc_pkg::out_t res_q, res_d;

  vccc_pkg::ring_ctrl_t ring_ctrl;
  vccc_pkg::ring_stat_t ring_stat;
  logic [7:0]           ring_data;

  logic       in_fire;
  logic       is_char, is_dot;
  logic [5:0] top;
  logic [9:0] offset;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign is_char = (mode_q == vccc_pkg::SEL_CHAR_S_L) || (mode_q == vccc_pkg::SEL_CHAR_M_L) ||
                   (mode_q == vccc_pkg::SEL_CHAR_L_L) || (mode_q == vccc_pkg::SEL_CHAR_S_R) ||
                   (mode_q == vccc_pkg::SEL_CHAR_M_R) || (mode_q == vccc_pkg::SEL_CHAR_L_R);
  assign is_dot  = (mode_q == vccc_pkg::SEL_DOT_L) || (mode_q == vccc_pkg::SEL_DOT_R);
  assign top     = in_word_i.word[11:6];
  assign offset  = right_q ? right_off_q : left_off_q;

  always_comb begin
    logic accepted;
    accepted   = 1'b0;
    mode_d     = mode_q;
    font_d     = font_q;
    right_d    = right_q;
    phase_d    = phase_q;
    refresh_d  = refresh_q;
    use_ring_d = 1'b0;
    ring_ctrl  = '0;
    res_d      = '0;
    case (in_word_i.operation)
      vccc_pkg::OP_FUNCTION: begin
        accepted = 1'b1;
        case (in_word_i.word)
          vccc_pkg::SEL_DOT_L: begin
            font_d = 2'd0; right_d = 1'b0;
          end
          vccc_pkg::SEL_DOT_R: begin
            font_d = 2'd0; right_d = 1'b1;
          end
          vccc_pkg::SEL_CHAR_S_L: begin
            font_d = 2'd1; right_d = 1'b0;
          end
          vccc_pkg::SEL_CHAR_M_L: begin
            font_d = 2'd2; right_d = 1'b0;
          end
          vccc_pkg::SEL_CHAR_L_L: begin
            font_d = 2'd3; right_d = 1'b0;
          end
          vccc_pkg::SEL_CHAR_S_R: begin
            font_d = 2'd1; right_d = 1'b1;
          end
          vccc_pkg::SEL_CHAR_M_R: begin
            font_d = 2'd2; right_d = 1'b1;
          end
          vccc_pkg::SEL_CHAR_L_R: begin
            font_d = 2'd3; right_d = 1'b1;
          end
          vccc_pkg::SEL_KEYIN: begin
          end
          default: begin
            accepted = 1'b0;
          end
        endcase
        if (accepted) begin
          mode_d = in_word_i.word;
        end
      end
      vccc_pkg::OP_OUTPUT: begin
        if (is_char || is_dot) begin
          refresh_d = 1'b0;
          if (top >= vccc_pkg::TOP_Y_MIN) begin
            res_d.coordinate = {2'b00, in_word_i.word[8:0]};
            res_d.action     = is_dot ? vccc_pkg::ACT_DOT : vccc_pkg::ACT_SET_Y;
          end else if (top >= vccc_pkg::TOP_X_MIN) begin
            res_d.coordinate = {2'b00, in_word_i.word[8:0]} + {1'b0, offset};
            res_d.action     = vccc_pkg::ACT_SET_X;
          end else if (is_char) begin
            res_d.char_high = top;
            res_d.char_low  = in_word_i.word[5:0];
            res_d.action    = vccc_pkg::ACT_CHARS;
          end
        end
      end
      vccc_pkg::OP_READ: begin
        if (mode_q == vccc_pkg::SEL_KEYIN) begin
          res_d.action = vccc_pkg::ACT_READ;
          mode_d       = '0;
          if (in_word_i.key_code != 8'd0) begin
            res_d.read_data = in_word_i.key_code;
          end else if (!ring_stat.empty) begin
            phase_d = (phase_q >= 2'd2) ? 2'd0 : phase_q + 2'd1;
            if (phase_d == 2'd1) begin
              ring_ctrl.pop = 1'b1;
              use_ring_d    = 1'b1;
            end
          end
        end
      end
      vccc_pkg::OP_QUEUE: begin
        ring_ctrl.push = 1'b1;
      end
      vccc_pkg::OP_ACTIVATE: begin
        refresh_d = 1'b1;
      end
      vccc_pkg::OP_DISCONNECT: begin
        if (refresh_q) begin
          res_d.action = vccc_pkg::ACT_REFRESH;
          refresh_d    = 1'b0;
        end
      end
      default: begin
      end
    endcase
    res_d.accepted = accepted;
    res_d.font     = font_d;
    if (!in_fire) begin
      ring_ctrl = '0;
    end
  end

  vccc_key_ring u_key_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ring_ctrl),
    .push_data_i (in_word_i.key_code),
    .stat_o      (ring_stat),
    .rd_data_o   (ring_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_off_q  <= 10'd0;
      right_off_q <= 10'd512;
      mode_q      <= '0;
      font_q      <= '0;
      right_q     <= 1'b0;
      phase_q     <= '0;
      refresh_q   <= 1'b0;
      out_valid_q <= 1'b0;
      use_ring_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          vccc_pkg::CFG_LEFT_OFFSET:  left_off_q  <= cfg_data_i;
          vccc_pkg::CFG_RIGHT_OFFSET: right_off_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        mode_q      <= mode_d;
        font_q      <= font_d;
        right_q     <= right_d;
        phase_q     <= phase_d;
        refresh_q   <= refresh_d;
        use_ring_q  <= use_ring_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  always_comb begin
    out_word_o = res_q;
    if (use_ring_q) begin
      out_word_o.read_data = ring_data;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/vccc_key_ring.sv =====
// Key ring FIFO: memory with head and tail pointers and a registered read word.
module vccc_key_ring (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vccc_pkg::ring_ctrl_t ctrl_i,
  input  logic [7:0]           push_data_i,
  output vccc_pkg::ring_stat_t stat_o,
  output logic [7:0]           rd_data_o
);

  localparam int unsigned AW = vccc_pkg::RING_AW;

  logic [7:0]    mem_q [vccc_pkg::KEY_RING_DEPTH];
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [AW-1:0] head_next, tail_next;
  logic [7:0]    rd_q;

  assign head_next = (head_q == AW'(vccc_pkg::KEY_RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_next = (tail_q == AW'(vccc_pkg::KEY_RING_DEPTH - 1)) ? '0 : tail_q + 1'b1;

  assign stat_o.empty = (head_q == tail_q);
  assign stat_o.full  = (head_next == tail_q);

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (ctrl_i.push && !stat_o.full) begin
      head_d = head_next;
    end
    if (ctrl_i.pop) begin
      tail_d = tail_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && !stat_o.full) begin
      mem_q[head_q] <= push_data_i;
    end
    if (ctrl_i.pop) begin
      rd_q <= mem_q[tail_q];
    end
  end

  assign rd_data_o = rd_q;

endmodule
